FILE: hdl/etfs_pkg.sv
package etfs_pkg;

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_BYTE    = 2'd1,
        KIND_TIMEOUT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TIMEOUT  = 2'd1,
        STATUS_NO_FRAME = 2'd2
    } status_t;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam int PAYLOAD_BYTES = 9;

    // one byte of crc-8, msb first, no final xor
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (crc[7])
            begin
                crc = {crc[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

FILE: hdl/etfs_if.sv
interface etfs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface etfs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  temperature;
    logic [15:0] voltage_centivolts;
    logic [15:0] current_centiamps;
    logic [15:0] consumption;
    logic [15:0] erpm_hundreds;

    modport source (output valid, output status, output temperature,
                    output voltage_centivolts, output current_centiamps,
                    output consumption, output erpm_hundreds, input ready);
    modport sink (input valid, input status, input temperature,
                  input voltage_centivolts, input current_centiamps,
                  input consumption, input erpm_hundreds, output ready);
endinterface

FILE: hdl/esc_telemetry_frame_sync.sv
// a result is registered and shown on telemetry in the cycle after the item that causes it
// throughput: one item per cycle; byte_stream stalls only while a result waits
// crc is kept per window length in a row of byte-wide crc cells, one step per byte
// reset: asynchronous active low, clears the search flag, byte count and output valid
// window and crc cells are not reset, they are read only after a full window of bytes
module esc_telemetry_frame_sync #(
    parameter int FRAME_BYTES  = 10,
    parameter int SEARCH_LIMIT = 20
) (
    input  logic       clk,
    input  logic       rst_n,
    etfs_in_if.sink    byte_stream,
    etfs_out_if.source telemetry
);
    import etfs_pkg::*;

    localparam int WIN_LEN = FRAME_BYTES - 1;
    localparam int CNT_MAX = (SEARCH_LIMIT > FRAME_BYTES) ? SEARCH_LIMIT : FRAME_BYTES;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    logic [7:0]       win_reg [WIN_LEN];
    logic [7:0]       crc_reg [WIN_LEN];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             searching_reg;
    logic             searching_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [1:0]       status_reg;
    logic [7:0]       temp_reg;
    logic [15:0]      volt_reg;
    logic [15:0]      curr_reg;
    logic [15:0]      cons_reg;
    logic [15:0]      erpm_reg;

    logic             accept;
    logic             shift;
    logic             res_valid;
    status_t          res_status;
    logic [CNT_W-1:0] seen_inc;
    logic             crc_hit;
    logic [7:0]       pad [PAYLOAD_BYTES];

    for (genvar gi = 0; gi < PAYLOAD_BYTES; gi++)
    begin : g_pad
        if (gi < WIN_LEN)
        begin : g_win
            assign pad[gi] = win_reg[gi];
        end
        else
        begin : g_zero
            assign pad[gi] = 8'h00;
        end
    end

    assign byte_stream.ready = !out_valid_reg || telemetry.ready;
    assign accept            = byte_stream.valid && byte_stream.ready;
    assign seen_inc          = cnt_reg + CNT_W'(1);
    assign crc_hit           = (seen_inc >= CNT_W'(FRAME_BYTES))
                               && (crc_reg[WIN_LEN-1] == byte_stream.data_byte);

    always_comb
    begin
        searching_next = searching_reg;
        cnt_next       = cnt_reg;
        shift          = 1'b0;
        res_valid      = 1'b0;
        res_status     = STATUS_OK;
        if (accept)
        begin
            case (byte_stream.kind)
                KIND_START:
                begin
                    searching_next = 1'b1;
                    cnt_next       = '0;
                end
                KIND_BYTE:
                begin
                    if (searching_reg)
                    begin
                        cnt_next = seen_inc;
                        if (crc_hit)
                        begin
                            searching_next = 1'b0;
                            res_valid      = 1'b1;
                            res_status     = STATUS_OK;
                        end
                        else
                        begin
                            shift = 1'b1;
                            if (seen_inc >= CNT_W'(SEARCH_LIMIT))
                            begin
                                searching_next = 1'b0;
                                res_valid      = 1'b1;
                                res_status     = STATUS_NO_FRAME;
                            end
                        end
                    end
                end
                KIND_TIMEOUT:
                begin
                    if (searching_reg)
                    begin
                        searching_next = 1'b0;
                        res_valid      = 1'b1;
                        res_status     = STATUS_TIMEOUT;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (telemetry.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            searching_reg <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            searching_reg <= searching_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // window shift and crc cells, cell j holds the crc of the last j+1 bytes
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            for (int i = 0; i < WIN_LEN - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WIN_LEN-1] <= byte_stream.data_byte;
            crc_reg[0] <= crc8_byte(8'h00, byte_stream.data_byte);
            for (int j = 1; j < WIN_LEN; j++)
            begin
                crc_reg[j] <= crc8_byte(crc_reg[j-1], byte_stream.data_byte);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            status_reg <= res_status;
            if (res_status == STATUS_OK)
            begin
                temp_reg <= pad[0];
                volt_reg <= {pad[1], pad[2]};
                curr_reg <= {pad[3], pad[4]};
                cons_reg <= {pad[5], pad[6]};
                erpm_reg <= {pad[7], pad[8]};
            end
            else
            begin
                temp_reg <= '0;
                volt_reg <= '0;
                curr_reg <= '0;
                cons_reg <= '0;
                erpm_reg <= '0;
            end
        end
    end

    assign telemetry.valid              = out_valid_reg;
    assign telemetry.status             = status_reg;
    assign telemetry.temperature        = temp_reg;
    assign telemetry.voltage_centivolts = volt_reg;
    assign telemetry.current_centiamps  = curr_reg;
    assign telemetry.consumption        = cons_reg;
    assign telemetry.erpm_hundreds      = erpm_reg;

endmodule

FILE: hdl/etfs_checker.sv
module etfs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [7:0]  temperature,
    input logic [15:0] voltage_centivolts,
    input logic [15:0] current_centiamps,
    input logic [15:0] consumption,
    input logic [15:0] erpm_hundreds
);
    import etfs_pkg::*;

    logic fields_zero;

    assign fields_zero = (temperature == 8'h00) && (voltage_centivolts == 16'h0000)
                         && (current_centiamps == 16'h0000) && (consumption == 16'h0000)
                         && (erpm_hundreds == 16'h0000);

    // a waiting result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // timeout and no-frame results carry zeroed fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_OK) |-> fields_zero)
        else $error("non-ok result with nonzero fields");

    // a result appears only after an accepted item
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without an accepted item");

    // input is not blocked while the output is free
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind esc_telemetry_frame_sync etfs_checker u_etfs_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (byte_stream.valid),
    .in_ready           (byte_stream.ready),
    .out_valid          (telemetry.valid),
    .out_ready          (telemetry.ready),
    .status             (telemetry.status),
    .temperature        (telemetry.temperature),
    .voltage_centivolts (telemetry.voltage_centivolts),
    .current_centiamps  (telemetry.current_centiamps),
    .consumption        (telemetry.consumption),
    .erpm_hundreds      (telemetry.erpm_hundreds)
);

FILE: sim/tb_esc_telemetry_frame_sync.sv
module tb_esc_telemetry_frame_sync;
    timeunit 1ns;
    timeprecision 1ps;

    import etfs_pkg::*;

    localparam int FRAME_LEN = 10;
    localparam int WINDOW_LEN = FRAME_LEN - 1;
    localparam int SEARCH_LIMIT = 20;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [7:0] POLY = 8'h07;
    localparam int ITEM_TARGET = 1050;
    localparam int PRESSURE_START = 120;
    localparam int PRESSURE_CYCLES = 300;

    typedef struct {
        logic [1:0]  status;
        logic [7:0]  temperature;
        logic [15:0] voltage_centivolts;
        logic [15:0] current_centiamps;
        logic [15:0] consumption;
        logic [15:0] erpm_hundreds;
    } telemetry_t;

    class telemetry_scoreboard;
        logic [WINDOW_LEN-1:0][7:0] window;
        int unsigned bytes_seen;
        bit searching;
        telemetry_t expected_telemetry[$];
        int failures;
        int frames_ok;
        int timeouts;
        int no_frames;

        function new();
            window = '0;
            bytes_seen = 0;
            searching = 1'b0;
            failures = 0;
            frames_ok = 0;
            timeouts = 0;
            no_frames = 0;
        endfunction

        // crc-8, msb first, zero start, no final xor; entry 0 goes in first
        static function logic [7:0] crc_of(input logic [WINDOW_LEN-1:0][7:0] bytes);
            logic [7:0] crc;
            crc = 8'h00;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                crc = crc ^ bytes[i];
                for (int b = 0; b < 8; b++)
                begin
                    crc = crc[7] ? ({crc[6:0], 1'b0} ^ POLY) : {crc[6:0], 1'b0};
                end
            end
            return crc;
        endfunction

        function void queue_result(input telemetry_t t);
            expected_telemetry.insert(expected_telemetry.size(), t);
        endfunction

        // returns 0 when the block ignores the item
        function bit note_item(input logic [1:0] kind, input logic [7:0] data);
            telemetry_t t;
            t.status = STATUS_OK;
            t.temperature = '0;
            t.voltage_centivolts = '0;
            t.current_centiamps = '0;
            t.consumption = '0;
            t.erpm_hundreds = '0;
            if (kind == KIND_START)
            begin
                searching = 1'b1;
                bytes_seen = 0;
                return 1'b1;
            end
            if (!searching || kind == KIND_UNUSED)
            begin
                return 1'b0;
            end
            if (kind == KIND_TIMEOUT)
            begin
                searching = 1'b0;
                t.status = STATUS_TIMEOUT;
                queue_result(t);
                return 1'b1;
            end
            bytes_seen++;
            if (bytes_seen >= FRAME_LEN && crc_of(window) == data)
            begin
                searching = 1'b0;
                t.temperature = window[0];
                t.voltage_centivolts = {window[1], window[2]};
                t.current_centiamps = {window[3], window[4]};
                t.consumption = {window[5], window[6]};
                t.erpm_hundreds = {window[7], window[8]};
                queue_result(t);
                return 1'b1;
            end
            window = {data, window[WINDOW_LEN-1:1]};
            if (bytes_seen >= SEARCH_LIMIT)
            begin
                searching = 1'b0;
                t.status = STATUS_NO_FRAME;
                queue_result(t);
            end
            return 1'b1;
        endfunction

        function void check_telemetry(input telemetry_t got);
            telemetry_t want;
            if (expected_telemetry.size() == 0)
            begin
                $error("unexpected result, status %0d", got.status);
                failures++;
                return;
            end
            want = expected_telemetry.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                failures++;
            end
            if (got.temperature !== want.temperature)
            begin
                $error("temperature: expected %0d, got %0d", want.temperature, got.temperature);
                failures++;
            end
            if (got.voltage_centivolts !== want.voltage_centivolts)
            begin
                $error("voltage_centivolts: expected %0d, got %0d",
                       want.voltage_centivolts, got.voltage_centivolts);
                failures++;
            end
            if (got.current_centiamps !== want.current_centiamps)
            begin
                $error("current_centiamps: expected %0d, got %0d",
                       want.current_centiamps, got.current_centiamps);
                failures++;
            end
            if (got.consumption !== want.consumption)
            begin
                $error("consumption: expected %0d, got %0d", want.consumption, got.consumption);
                failures++;
            end
            if (got.erpm_hundreds !== want.erpm_hundreds)
            begin
                $error("erpm_hundreds: expected %0d, got %0d",
                       want.erpm_hundreds, got.erpm_hundreds);
                failures++;
            end
            case (want.status)
                STATUS_OK:      frames_ok++;
                STATUS_TIMEOUT: timeouts++;
                default:        no_frames++;
            endcase
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    etfs_in_if  byte_stream();
    etfs_out_if telemetry();

    esc_telemetry_frame_sync dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .telemetry   (telemetry)
    );

    telemetry_scoreboard sb;
    int items_used;
    int sender_idle_pct;
    int receiver_stall_pct;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic send_item(input logic [1:0] kind, input logic [7:0] data);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            byte_stream.valid = 1'b0;
            @(negedge clk);
        end
        byte_stream.valid = 1'b1;
        byte_stream.kind = kind;
        byte_stream.data_byte = data;
        do
            @(posedge clk);
        while (!byte_stream.ready);
        if (sb.note_item(kind, data))
        begin
            items_used++;
        end
    endtask

    task automatic send_frame(input logic [WINDOW_LEN-1:0][7:0] payload, input bit corrupt);
        logic [7:0] crc;
        crc = telemetry_scoreboard::crc_of(payload);
        if (corrupt)
        begin
            crc = crc ^ (8'h01 << $urandom_range(7));
        end
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            send_item(KIND_BYTE, payload[i]);
        end
        send_item(KIND_BYTE, crc);
    endtask

    task automatic random_sequence();
        logic [WINDOW_LEN-1:0][7:0] payload;
        int pick;
        int junk;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            send_item(KIND_START, 8'($urandom_range(255)));
            junk = ($urandom_range(99) < 75) ? $urandom_range(0, 3) : $urandom_range(4, 12);
            repeat (junk) send_item(KIND_BYTE, 8'($urandom_range(255)));
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                case ($urandom_range(9))
                    0:       payload[i] = 8'h00;
                    1:       payload[i] = 8'hff;
                    default: payload[i] = 8'($urandom_range(255));
                endcase
            end
            send_frame(payload, $urandom_range(99) < 8);
            if ($urandom_range(99) < 20)
            begin
                repeat ($urandom_range(1, 3)) send_item(KIND_BYTE, 8'($urandom_range(255)));
            end
        end
        else if (pick < 80)
        begin
            send_item(KIND_START, 8'($urandom_range(255)));
            repeat ($urandom_range(0, 12)) send_item(KIND_BYTE, 8'($urandom_range(255)));
            send_item(KIND_TIMEOUT, 8'($urandom_range(255)));
        end
        else if (pick < 88)
        begin
            send_item(KIND_START, 8'($urandom_range(255)));
            repeat ($urandom_range(1, 8)) send_item(KIND_BYTE, 8'($urandom_range(255)));
        end
        else if (pick < 95)
        begin
            repeat ($urandom_range(1, 5))
                send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
        end
        else
        begin
            send_item(KIND_START, 8'($urandom_range(255)));
            repeat ($urandom_range(20, 22)) send_item(KIND_BYTE, 8'($urandom_range(255)));
        end
    endtask

    // receiver, with one long hold-off so the block backs up
    initial
    begin
        int cycle_count;
        int hold_left;
        cycle_count = 0;
        hold_left = 0;
        telemetry.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cycle_count++;
            if (cycle_count == PRESSURE_START)
            begin
                hold_left = PRESSURE_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                telemetry.ready = 1'b0;
            end
            else
            begin
                telemetry.ready = ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        telemetry_t got;
        if (rst_n && telemetry.valid && telemetry.ready)
        begin
            got.status = telemetry.status;
            got.temperature = telemetry.temperature;
            got.voltage_centivolts = telemetry.voltage_centivolts;
            got.current_centiamps = telemetry.current_centiamps;
            got.consumption = telemetry.consumption;
            got.erpm_hundreds = telemetry.erpm_hundreds;
            sb.check_telemetry(got);
        end
    end

    initial
    begin
        #2_000_000;
        $display("esc_telemetry_frame_sync test failed");
        $finish;
    end

    initial
    begin
        logic [WINDOW_LEN-1:0][7:0] payload;
        rst_n = 1'b0;
        byte_stream.valid = 1'b0;
        byte_stream.kind = KIND_START;
        byte_stream.data_byte = 8'h00;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        items_used = 0;
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // idle items are dropped
        send_item(KIND_BYTE, 8'hff);
        send_item(KIND_TIMEOUT, 8'h00);
        send_item(KIND_UNUSED, 8'h5a);
        // all-zero frame, all-ones frame
        send_item(KIND_START, 8'h00);
        send_frame('0, 1'b0);
        send_item(KIND_START, 8'hff);
        payload = '1;
        send_frame(payload, 1'b0);
        // timeout during a search
        send_item(KIND_START, 8'h00);
        send_item(KIND_BYTE, 8'h80);
        send_item(KIND_TIMEOUT, 8'hff);

        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 17 : 73) : 0;
            receiver_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 17 : 73) : 0;
            while (items_used < (phase + 1) * ITEM_TARGET / 4)
            begin
                random_sequence();
            end
        end

        @(negedge clk);
        byte_stream.valid = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        while (sb.expected_telemetry.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("covered %0d items: %0d frames decoded, %0d timeouts, %0d searches gave up",
                 items_used, sb.frames_ok, sb.timeouts, sb.no_frames);
        if (sb.failures == 0)
        begin
            $display("esc_telemetry_frame_sync test passed");
        end
        else
        begin
            $display("esc_telemetry_frame_sync test failed");
        end
        $finish;
    end

endmodule

FILE: esc_telemetry_frame_sync.f
hdl/etfs_pkg.sv
hdl/etfs_if.sv
hdl/esc_telemetry_frame_sync.sv
hdl/etfs_checker.sv
sim/tb_esc_telemetry_frame_sync.sv
